FILE: design/assert_macros.svh
// Assertion macros shared by the order book tracker RTL.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: design/obbpt_pkg.sv
// Package for the order book tracker: word types and back-end states.
// Depends on nothing.
package obbpt_pkg;
   localparam int PriceW = 32;
   localparam int QtyW = 48;
   localparam int TimeW = 63;

   typedef struct packed {
      logic              side;
      logic [PriceW-1:0] price_ticks;
      logic [QtyW-1:0]   quantity;
      logic [TimeW-1:0]  update_time;
   } req_word_type;

   typedef struct packed {
      logic              accepted;
      logic              table_full;
      logic              bid_valid;
      logic [PriceW-1:0] best_bid_price;
      logic [QtyW-1:0]   best_bid_qty;
      logic              ask_valid;
      logic [PriceW-1:0] best_ask_price;
      logic [QtyW-1:0]   best_ask_qty;
      logic [TimeW-1:0]  book_time;
   } rsp_word_type;

   // classified command passed front to back
   typedef struct packed {
      logic              accepted;
      logic              side;
      logic [PriceW-1:0] price;
      logic [QtyW-1:0]   qty;
      logic [TimeW-1:0]  book_time;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_SEND
   } back_state_type;
endpackage

FILE: design/order_book_best_price_tracker_top.sv
// Top level of the order book top-of-book tracker.
// Depends on obbpt_pkg, obbpt_front, obbpt_back and assert_macros.svh.
//
//   channel | direction | handshake
//   req     | in        | push / full
//   rsp     | out       | empty / pop
//
// In the back end a word is taken from the queue, applied, then sent.
// It goes from the command register through the apply and send states to rsp_word.
// Removing the best level adds a serial rescan over the table.
// Reset is synchronous and empties both tables.
// Front queue holds two words, so push proceeds while a result waits on pop.
`include "assert_macros.svh"
module order_book_best_price_tracker_top import obbpt_pkg::*; #(
   parameter int LEVELS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   obbpt_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_word(req_word),
      .cmd_take(cmd_take), .cmd_valid(cmd_valid), .cmd(cmd)
   );

   obbpt_back #(.LEVELS(LEVELS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );

   // result held while not popped
   `ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty)
   // a refused word never reports a dropped insert
   `ASSERT_IMPLIES(a_full_acc, clock, reset, !empty && rsp_word.table_full,
      rsp_word.accepted)
   // empty bid side reports zero price
   `ASSERT_IMPLIES(a_bid_zero, clock, reset, !empty && !rsp_word.bid_valid,
      rsp_word.best_bid_price == '0)
endmodule

FILE: design/obbpt_front.sv
// Front end: time check and two-entry command queue.
// Depends on obbpt_pkg.
module obbpt_front import obbpt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   input  logic         cmd_take,
   output logic         cmd_valid,
   output cmd_type      cmd
);
   cmd_type            q_ff [2];
   cmd_type            q_in [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic [TimeW-1:0]   time_ff, time_in;
   cmd_type            c;
   logic               do_push;

   assign full = (cnt_ff == 2'd2);
   assign do_push = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      c.accepted = (req_word.update_time >= time_ff);
      c.side = req_word.side;
      c.price = req_word.price_ticks;
      c.qty = req_word.quantity;
      c.book_time = c.accepted ? req_word.update_time : time_ff;
      time_in = do_push ? c.book_time : time_ff;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      if (cmd_take && cmd_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (do_push) begin
         q_in[cnt_in[0]] = c;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
         time_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         time_ff <= time_in;
      end
   end
endmodule

FILE: design/obbpt_back.sv
// Back end: level tables in flops, parallel match, serial rescan, result register.
// Depends on obbpt_pkg.
module obbpt_back import obbpt_pkg::*; #(
   parameter int LEVELS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_take,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);
   localparam int IdxW = $clog2(LEVELS);

   logic              used_ff [2][LEVELS];
   logic              used_in [2][LEVELS];
   logic [PriceW-1:0] price_ff [2][LEVELS];
   logic [QtyW-1:0]   qty_ff [2][LEVELS];
   logic [PriceW-1:0] best_ff [2], best_in [2];
   logic [IdxW-1:0]   bidx_ff [2], bidx_in [2];
   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic              full_ff, full_in;
   logic [IdxW:0]     scan_ff, scan_in;
   logic              have_ff, have_in;
   rsp_word_type      out_ff, out_in;
   logic              ovalid_ff, ovalid_in;
   logic              hit, free_ok, any_used, wr_en;
   logic [IdxW-1:0]   hit_idx, free_idx, wr_idx;
   logic              s;
   logic [IdxW-1:0]   si;

   assign s = cmd_ff.side;
   assign si = scan_ff[IdxW-1:0];

   always_comb begin
      hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0; any_used = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (used_ff[s][i] && price_ff[s][i] == cmd_ff.price) begin
            hit = 1'b1; hit_idx = IdxW'(i);
         end
         if (!used_ff[s][i]) begin
            free_ok = 1'b1; free_idx = IdxW'(i);
         end
         if (used_ff[s][i]) any_used = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (cmd_valid) state_in = ST_APPLY;
         ST_APPLY: if (cmd_ff.accepted && cmd_ff.qty == '0 && hit
                       && best_ff[s] == cmd_ff.price) state_in = ST_SCAN;
                   else state_in = ST_SEND;
         ST_SCAN:  if (scan_ff == (IdxW+1)'(LEVELS - 1)) state_in = ST_SEND;
         ST_SEND:  if (!ovalid_ff || pop) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_take = (state_ff == ST_IDLE);
      cmd_in = (state_ff == ST_IDLE) ? cmd : cmd_ff;
      used_in = used_ff;
      best_in = best_ff;
      bidx_in = bidx_ff;
      full_in = full_ff;
      scan_in = scan_ff;
      have_in = have_ff;
      wr_en = 1'b0;
      wr_idx = hit ? hit_idx : free_idx;
      ovalid_in = ovalid_ff && !pop;
      out_in = out_ff;
      case (state_ff)
         ST_IDLE: full_in = 1'b0;
         ST_APPLY: begin
            scan_in = '0; have_in = 1'b0;
            if (cmd_ff.accepted) begin
               if (cmd_ff.qty != '0) begin
                  if (hit) wr_en = 1'b1;
                  else if (!free_ok) full_in = 1'b1;
                  else begin
                     wr_en = 1'b1;
                     used_in[s][free_idx] = 1'b1;
                     if (!any_used || (s ? cmd_ff.price > best_ff[s]
                                         : cmd_ff.price < best_ff[s])) begin
                        best_in[s] = cmd_ff.price;
                        bidx_in[s] = free_idx;
                     end
                  end
               end else if (hit) begin
                  used_in[s][hit_idx] = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (used_ff[s][si] && (!have_ff || (s ? price_ff[s][si] > best_ff[s]
                                                 : price_ff[s][si] < best_ff[s]))) begin
               best_in[s] = price_ff[s][si];
               bidx_in[s] = si;
               have_in = 1'b1;
            end else if (!have_ff && si == '0) begin
               best_in[s] = '0;
            end
         end
         ST_SEND: begin
            if (!ovalid_ff || pop) begin
               ovalid_in = 1'b1;
               out_in.accepted = cmd_ff.accepted;
               out_in.table_full = full_ff;
               out_in.book_time = cmd_ff.book_time;
               out_in.bid_valid = 1'b0;
               out_in.best_bid_price = '0;
               out_in.best_bid_qty = '0;
               out_in.ask_valid = 1'b0;
               out_in.best_ask_price = '0;
               out_in.best_ask_qty = '0;
               for (int i = 0; i < LEVELS; i++) begin
                  if (used_ff[1][i]) out_in.bid_valid = 1'b1;
                  if (used_ff[0][i]) out_in.ask_valid = 1'b1;
               end
               if (out_in.bid_valid) begin
                  out_in.best_bid_price = best_ff[1];
                  out_in.best_bid_qty = qty_ff[1][bidx_ff[1]];
               end
               if (out_in.ask_valid) begin
                  out_in.best_ask_price = best_ff[0];
                  out_in.best_ask_qty = qty_ff[0][bidx_ff[0]];
               end
            end
         end
         default: ;
      endcase
   end

   assign empty = !ovalid_ff;
   assign rsp_word = out_ff;

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      scan_ff <= scan_in;
      have_ff <= have_in;
      full_ff <= full_in;
      bidx_ff <= bidx_in;
      if (wr_en) begin
         price_ff[s][wr_idx] <= cmd_ff.price;
         qty_ff[s][wr_idx] <= cmd_ff.qty;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
         best_ff[0] <= '0;
         best_ff[1] <= '0;
         for (int j = 0; j < LEVELS; j++) begin
            used_ff[0][j] <= 1'b0;
            used_ff[1][j] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         best_ff <= best_in;
         used_ff <= used_in;
      end
   end
endmodule
